[rtl/mct_pkg.sv]
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the match/capture timer: transaction
// structs, command codes and the word register map.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int MATCH_CHANNELS_DEF   = 4;
  localparam int CAPTURE_CHANNELS_DEF = 4;
  localparam int COUNT_WIDTH_DEF      = 32;

  // first capture flag bit
  localparam int CAP_FLAG_BASE = 4;

  // commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  // register map
  localparam logic [3:0] REG_FLAGS    = 4'd0;
  localparam logic [3:0] REG_CONTROL  = 4'd1;
  localparam logic [3:0] REG_COUNTER  = 4'd2;
  localparam logic [3:0] REG_PLIMIT   = 4'd3;
  localparam logic [3:0] REG_PCOUNT   = 4'd4;
  localparam logic [3:0] REG_MATCHCTL = 4'd5;
  localparam logic [3:0] REG_MATCH0   = 4'd6;
  localparam logic [3:0] REG_CAPCTL   = 4'd10;
  localparam logic [3:0] REG_CAPTURE0 = 4'd11;

  // control register bits
  localparam int CTL_RUN_BIT  = 0;
  localparam int CTL_HOLD_BIT = 1;

  // per-channel control bit offsets
  localparam int MCTL_INT   = 0;
  localparam int MCTL_RESET = 1;
  localparam int MCTL_STOP  = 2;
  localparam int CCTL_RISE  = 0;
  localparam int CCTL_FALL  = 1;
  localparam int CCTL_INT   = 2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [3:0]  capture_pins;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  interrupt_flags;
    logic        irq;
  } out_item_t;

endpackage

[rtl/mct_in_stage.sv]
// ----------------------------------------------------------------------------
// mct_in_stage
// Input register: holds one transaction until the execute stage takes it.
// ----------------------------------------------------------------------------
module mct_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mct_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              q_valid,
  output mct_pkg::in_item_t q_data
);
  import mct_pkg::*;

  logic     full_r, full_nxt;
  in_item_t data_r, data_nxt;
  logic     load;

  assign in_stall = full_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    full_nxt = full_r;
    data_nxt = data_r;
    if (load) begin
      full_nxt = 1'b1;
      data_nxt = in_data;
    end else if (advance) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q_valid = full_r;
  assign q_data  = data_r;

endmodule

[rtl/mct_exec.sv]
// ----------------------------------------------------------------------------
// mct_exec
// Timer state and execute logic: tick, register read/write, capture sample.
// State updates when fire is high; result is combinational.
// ----------------------------------------------------------------------------
module mct_exec #(
  parameter int MATCH_CHANNELS   = mct_pkg::MATCH_CHANNELS_DEF,
  parameter int CAPTURE_CHANNELS = mct_pkg::CAPTURE_CHANNELS_DEF,
  parameter int COUNT_WIDTH      = mct_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mct_pkg::in_item_t  item,
  output mct_pkg::out_item_t result
);
  import mct_pkg::*;

  localparam int MCTL_W = 3 * MATCH_CHANNELS;
  localparam int CCTL_W = 3 * CAPTURE_CHANNELS;

  logic [7:0]             flags_r, flags_nxt;
  logic                   run_r, run_nxt;
  logic                   hold_r, hold_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_step;
  logic [31:0]            plim_r, plim_nxt;
  logic [31:0]            pcnt_r, pcnt_nxt;
  logic [MCTL_W-1:0]      mctl_r, mctl_nxt;
  logic [COUNT_WIDTH-1:0] match_r [MATCH_CHANNELS];
  logic [COUNT_WIDTH-1:0] match_nxt [MATCH_CHANNELS];
  logic [CCTL_W-1:0]      cctl_r, cctl_nxt;
  logic [COUNT_WIDTH-1:0] capt_r [CAPTURE_CHANNELS];
  logic [COUNT_WIDTH-1:0] capt_nxt [CAPTURE_CHANNELS];
  logic [CAPTURE_CHANNELS-1:0] pins_r, pins_nxt, pins_now;
  logic                   zero_hit;
  logic                   rise, fall;
  logic [31:0]            rd;

  assign pins_now = item.capture_pins[CAPTURE_CHANNELS-1:0];

  // counter step on prescale rollover
  always_comb begin
    zero_hit = 1'b0;
    for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
      if (mctl_r[3*ch + MCTL_RESET] && (match_r[ch] == cnt_r)) begin
        zero_hit = 1'b1;
      end
    end
    cnt_step = zero_hit ? '0 : cnt_r + COUNT_WIDTH'(1);
  end

  always_comb begin
    flags_nxt = flags_r;
    run_nxt   = run_r;
    hold_nxt  = hold_r;
    cnt_nxt   = cnt_r;
    plim_nxt  = plim_r;
    pcnt_nxt  = pcnt_r;
    mctl_nxt  = mctl_r;
    cctl_nxt  = cctl_r;
    pins_nxt  = pins_r;
    match_nxt = match_r;
    capt_nxt  = capt_r;
    rd        = '0;
    rise      = 1'b0;
    fall      = 1'b0;

    case (item.command)
      CMD_TICK: begin
        if (hold_r) begin
          cnt_nxt  = '0;
          pcnt_nxt = '0;
        end else if (run_r) begin
          if (pcnt_r != plim_r) begin
            pcnt_nxt = pcnt_r + 32'd1;
          end else begin
            pcnt_nxt = '0;
            cnt_nxt  = cnt_step;
            for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
              if (match_r[ch] == cnt_step) begin
                if (mctl_r[3*ch + MCTL_INT]) begin
                  flags_nxt[ch] = 1'b1;
                end
                if (mctl_r[3*ch + MCTL_STOP]) begin
                  run_nxt = 1'b0;
                end
              end
            end
          end
        end
      end

      CMD_READ: begin
        case (item.reg_index)
          REG_FLAGS:    rd = 32'(flags_r);
          REG_CONTROL:  rd = 32'({hold_r, run_r});
          REG_COUNTER:  rd = 32'(cnt_r);
          REG_PLIMIT:   rd = plim_r;
          REG_PCOUNT:   rd = pcnt_r;
          REG_MATCHCTL: rd = 32'(mctl_r);
          REG_CAPCTL:   rd = 32'(cctl_r);
          default: begin
            for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
              if (item.reg_index == 4'(REG_MATCH0 + ch)) begin
                rd = 32'(match_r[ch]);
              end
            end
            for (int ch = 0; ch < CAPTURE_CHANNELS; ch++) begin
              if (item.reg_index == 4'(REG_CAPTURE0 + ch)) begin
                rd = 32'(capt_r[ch]);
              end
            end
          end
        endcase
      end

      CMD_WRITE: begin
        case (item.reg_index)
          REG_FLAGS:    flags_nxt = flags_r & ~item.write_data[7:0];
          REG_CONTROL: begin
            run_nxt  = item.write_data[CTL_RUN_BIT];
            hold_nxt = item.write_data[CTL_HOLD_BIT];
          end
          REG_COUNTER:  cnt_nxt  = item.write_data[COUNT_WIDTH-1:0];
          REG_PLIMIT:   plim_nxt = item.write_data;
          REG_PCOUNT:   pcnt_nxt = item.write_data;
          REG_MATCHCTL: mctl_nxt = item.write_data[MCTL_W-1:0];
          REG_CAPCTL:   cctl_nxt = item.write_data[CCTL_W-1:0];
          default: begin
            for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
              if (item.reg_index == 4'(REG_MATCH0 + ch)) begin
                match_nxt[ch] = item.write_data[COUNT_WIDTH-1:0];
              end
            end
          end
        endcase
      end

      CMD_SAMPLE: begin
        for (int ch = 0; ch < CAPTURE_CHANNELS; ch++) begin
          rise = !pins_r[ch] && pins_now[ch];
          fall = pins_r[ch] && !pins_now[ch];
          if ((rise && cctl_r[3*ch + CCTL_RISE]) || (fall && cctl_r[3*ch + CCTL_FALL])) begin
            capt_nxt[ch] = cnt_r;
            if (cctl_r[3*ch + CCTL_INT]) begin
              flags_nxt[CAP_FLAG_BASE + ch] = 1'b1;
            end
          end
        end
        pins_nxt = pins_now;
      end

      default: ;
    endcase
  end

  assign result.read_data       = rd;
  assign result.interrupt_flags = flags_nxt;
  assign result.irq             = |flags_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      run_r   <= 1'b0;
      hold_r  <= 1'b0;
      cnt_r   <= '0;
      plim_r  <= '0;
      pcnt_r  <= '0;
      mctl_r  <= '0;
      cctl_r  <= '0;
      pins_r  <= '0;
      for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
        match_r[ch] <= '0;
      end
      for (int ch = 0; ch < CAPTURE_CHANNELS; ch++) begin
        capt_r[ch] <= '0;
      end
    end else if (fire) begin
      flags_r <= flags_nxt;
      run_r   <= run_nxt;
      hold_r  <= hold_nxt;
      cnt_r   <= cnt_nxt;
      plim_r  <= plim_nxt;
      pcnt_r  <= pcnt_nxt;
      mctl_r  <= mctl_nxt;
      cctl_r  <= cctl_nxt;
      pins_r  <= pins_nxt;
      match_r <= match_nxt;
      capt_r  <= capt_nxt;
    end
  end

endmodule

[rtl/match_capture_timer_core.sv]
// ----------------------------------------------------------------------------
// match_capture_timer_core
// Timer with 32-bit prescaler, match and capture channels, driven by a
// stream of tick / read / write / pin-sample transactions, one result each.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid/in_stall   | mct_pkg::in_item_t  in_data
//   out     | output    | out_valid/out_stall | mct_pkg::out_item_t out_data
//
// Cycles: one transaction per clock while out_stall is low. A transaction
// accepted into the input register is executed out of it, and its result
// is presented from the output register. The longest path is the counter
// increment feeding the per-channel match compare.
// Reset: synchronous, active low; every timer register clears.
// Stalls: out_stall holds the result register; one more transaction waits
// in the input register, after which in_stall rises.
//
module match_capture_timer_core #(
  parameter int MATCH_CHANNELS   = mct_pkg::MATCH_CHANNELS_DEF,
  parameter int CAPTURE_CHANNELS = mct_pkg::CAPTURE_CHANNELS_DEF,
  parameter int COUNT_WIDTH      = mct_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mct_pkg::out_item_t out_data
);
  import mct_pkg::*;

  logic      advance;     // execute stage may move a transaction out
  logic      q_valid;
  in_item_t  q_data;
  logic      fire;        // transaction executes this cycle
  out_item_t result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Result register is free when empty or being drained this cycle.
  assign advance = !out_valid_r || !out_stall;
  assign fire    = q_valid && advance;

  mct_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  mct_exec #(
    .MATCH_CHANNELS   (MATCH_CHANNELS),
    .CAPTURE_CHANNELS (CAPTURE_CHANNELS),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (q_data),
    .result (result)
  );

  // Output register: loads on fire, holds while stalled.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/mct_checker.sv]
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks for the timer core, attached by bind.
// ----------------------------------------------------------------------------
module mct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input mct_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mct_pkg::out_item_t out_data
);
  import mct_pkg::*;

  // a stalled input transaction stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // irq tracks the flag byte
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.irq == (out_data.interrupt_flags != 8'd0)))
    else $error("irq does not match interrupt flags");

  // input backs up only behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result path is free");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind match_capture_timer_core mct_checker u_mct_checker (.*);
